// ===== rtl/mlfq_pkg.sv =====
package mlfq_pkg;

    // Sizing
    localparam int TASK_SLOTS = 16;
    localparam int CORES      = 4;
    localparam int CORE_LIM   = (CORES < 4) ? CORES : 4;
    localparam int TIDX_W     = $clog2(TASK_SLOTS);
    localparam int CIDX_W     = 2;
    localparam int NT_W       = 5;
    localparam int NC_W       = 3;
    localparam int Q_W        = 4;

    typedef enum logic [1:0] {
        TS_READY = 2'd0,
        TS_RUN   = 2'd1,
        TS_WAIT  = 2'd2,
        TS_DONE  = 2'd3
    } tstate_t;

    typedef enum logic [2:0] {
        OC_IDLE    = 3'd0,
        OC_CONT    = 3'd1,
        OC_FINISH  = 3'd2,
        OC_IOWAIT  = 3'd3,
        OC_EXPIRED = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SCAN,
        PH_ASSIGN,
        PH_RUN,
        PH_EMIT
    } phase_t;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    typedef enum logic {
        REG_ACTIVE_CORES = 1'b0,
        REG_TASK_COUNT   = 1'b1
    } reg_idx_t;

    // One task slot as held in a cell
    typedef struct packed {
        tstate_t     state;
        logic [1:0]  level;
        logic [15:0] left;
        logic [15:0] run_since_io;
        logic [15:0] io_left;
        logic [15:0] arrival;
        logic [15:0] io_every;
        logic [15:0] io_time;
    } task_rec_t;

    typedef struct packed {
        logic        mode;
        logic [3:0]  slot;
        logic [15:0] arrival_tick;
        logic [15:0] burst_length;
        logic [15:0] io_interval;
        logic [15:0] io_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  core_index;
        logic        core_busy;
        logic [3:0]  task_index;
        logic [1:0]  run_level;
        logic [2:0]  outcome;
        logic [15:0] tick_number;
        logic        all_done;
        logic        last;
    } out_item_t;

    function automatic logic [Q_W-1:0] quantum_for(input logic [1:0] lvl);
        logic [Q_W-1:0] q;
        q = Q_W'(8);
        if (lvl == 2'd0) q = Q_W'(2);
        else if (lvl == 2'd1) q = Q_W'(4);
        return q;
    endfunction

endpackage

// ===== rtl/mlfq_cell.sv =====
module mlfq_cell
    import mlfq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      shift_en,
    input  logic      load_en,
    input  task_rec_t rec_in,
    input  task_rec_t load_rec,
    output task_rec_t rec_out
);

    task_rec_t rec_reg;

    // Slot record: loaded directly, or handed on from the neighbour
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            // ready at level 0, all counts clear
            rec_reg <= '0;
        end else if (load_en) begin
            rec_reg <= load_rec;
        end else if (shift_en) begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

// ===== rtl/mlfq_multicore_scheduler_top.sv =====
// Multilevel feedback scheduler for up to four cores.
// Input channel s_valid/s_ready/s_data: a load request writes one task slot;
// a tick request advances the schedule by one tick.
// Result channel m_valid/m_ready/m_data: a tick gives one result per
// scheduled core, core 0 first, the last one flagged; a load gives none.
// Configuration: cfg_we/cfg_index/cfg_data, written while the block is idle.
// Task slots live in a ring of cells that rotates one slot per cycle, in
// the scan and run phases only, past a single update point at its head.
// A tick takes one full rotation for io countdown and candidate picking,
// a core assignment step, a second rotation to run the cores, then one
// result at a time into the output register; the next request is taken
// only once the last result is in the output register.
// Reset (aresetn low, synchronous) makes every slot ready at level 0, all
// cores idle, the tick counter zero, one active core and task_count 16.
// When the receiver stalls, results wait in the output register and the
// block holds in its emit phase; no result is lost.
module mlfq_multicore_scheduler_top
    import mlfq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [NT_W-1:0]   cfg_data
);

    phase_t            phase_reg, phase_next;
    logic [TIDX_W-1:0] cnt_reg, cnt_next;
    logic [NC_W-1:0]   act_cores_reg, act_cores_next;
    logic [NT_W-1:0]   task_count_reg, task_count_next;
    logic [NC_W-1:0]   nc_reg, nc_next;
    logic [NT_W-1:0]   nt_reg, nt_next;
    logic [15:0]       tick_reg, tick_next;
    logic [NT_W-1:0]   done_reg, done_next;
    logic [CIDX_W-1:0] emit_reg, emit_next;

    logic              cv_reg [CORES];
    logic              cv_next [CORES];
    logic [TIDX_W-1:0] ct_reg [CORES];
    logic [TIDX_W-1:0] ct_next [CORES];
    logic [Q_W-1:0]    cq_reg [CORES];
    logic [Q_W-1:0]    cq_next [CORES];

    logic              cand_v_reg [CORES];
    logic              cand_v_next [CORES];
    logic [TIDX_W-1:0] cand_i_reg [CORES];
    logic [TIDX_W-1:0] cand_i_next [CORES];
    logic [1:0]        cand_l_reg [CORES];
    logic [1:0]        cand_l_next [CORES];

    logic              rb_reg [CORES];
    logic              rb_next [CORES];
    logic [1:0]        rl_reg [CORES];
    logic [1:0]        rl_next [CORES];
    outcome_t          ro_reg [CORES];
    outcome_t          ro_next [CORES];

    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    task_rec_t         ring [TASK_SLOTS];
    task_rec_t         head_next;
    task_rec_t         load_rec;
    logic              shift_en;
    logic              load_fire;

    // Ring of task cells; the last cell takes the updated head record
    assign load_fire = s_valid && s_ready && (s_data.mode == MODE_LOAD);
    assign shift_en  = (phase_reg == PH_SCAN) || (phase_reg == PH_RUN);

    always_comb begin
        load_rec.state        = TS_READY;
        load_rec.level        = 2'd0;
        load_rec.left         = s_data.burst_length;
        load_rec.run_since_io = 16'd0;
        load_rec.io_left      = 16'd0;
        load_rec.arrival      = s_data.arrival_tick;
        load_rec.io_every     = s_data.io_interval;
        load_rec.io_time      = s_data.io_length;
    end

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        task_rec_t nb;
        if (g == TASK_SLOTS - 1) begin : g_tail
            assign nb = head_next;
        end else begin : g_mid
            assign nb = ring[g+1];
        end
        mlfq_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .load_en  (load_fire && (s_data.slot == TIDX_W'(g))),
            .rec_in   (nb),
            .load_rec (load_rec),
            .rec_out  (ring[g])
        );
    end

    // Sequencer and head update
    always_comb begin
        task_rec_t         r;
        logic              in_use;
        logic              elig;
        logic              hit;
        logic [CIDX_W-1:0] hc;
        logic [2:0]        pos;
        logic [2:0]        k;
        logic [15:0]       run_new;
        logic [Q_W-1:0]    q_new;

        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        act_cores_next  = act_cores_reg;
        task_count_next = task_count_reg;
        nc_next         = nc_reg;
        nt_next         = nt_reg;
        tick_next       = tick_reg;
        done_next       = done_reg;
        emit_next       = emit_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        for (int c = 0; c < CORES; c++) begin
            cv_next[c]     = cv_reg[c];
            ct_next[c]     = ct_reg[c];
            cq_next[c]     = cq_reg[c];
            cand_v_next[c] = cand_v_reg[c];
            cand_i_next[c] = cand_i_reg[c];
            cand_l_next[c] = cand_l_reg[c];
            rb_next[c]     = rb_reg[c];
            rl_next[c]     = rl_reg[c];
            ro_next[c]     = ro_reg[c];
        end

        r        = ring[0];
        in_use   = NT_W'(cnt_reg) < nt_reg;
        elig     = 1'b0;
        hit      = 1'b0;
        hc       = '0;
        pos      = '0;
        k        = '0;
        run_new  = '0;
        q_new    = '0;

        if (m_ready) m_valid_next = 1'b0;

        if (cfg_we) begin
            if (cfg_index == REG_ACTIVE_CORES) act_cores_next = cfg_data[NC_W-1:0];
            else task_count_next = cfg_data;
        end

        unique case (phase_reg)
            PH_IDLE: begin
                if (s_valid) begin
                    if (s_data.mode == MODE_LOAD) begin
                        for (int c = 0; c < CORES; c++)
                            if (cv_reg[c] && ct_reg[c] == s_data.slot) cv_next[c] = 1'b0;
                    end else begin
                        if (act_cores_reg == '0) nc_next = NC_W'(1);
                        else if (act_cores_reg > NC_W'(CORE_LIM)) nc_next = NC_W'(CORE_LIM);
                        else nc_next = act_cores_reg;
                        if (task_count_reg == '0) nt_next = NT_W'(1);
                        else if (task_count_reg > NT_W'(TASK_SLOTS)) nt_next = NT_W'(TASK_SLOTS);
                        else nt_next = task_count_reg;
                        for (int c = 0; c < CORES; c++) cand_v_next[c] = 1'b0;
                        cnt_next   = '0;
                        phase_next = PH_SCAN;
                    end
                end
            end

            PH_SCAN: begin
                // Release tasks held by cores no longer scheduled
                for (int c = 0; c < CORES; c++) begin
                    if (NC_W'(c) >= nc_reg && cv_reg[c] && ct_reg[c] == cnt_reg) begin
                        r.state    = TS_READY;
                        cv_next[c] = 1'b0;
                    end
                end
                // I/O countdown
                if (in_use && r.state == TS_WAIT) begin
                    if (r.io_left <= 16'd1) begin
                        r.io_left      = 16'd0;
                        r.state        = TS_READY;
                        r.level        = 2'd0;
                        r.run_since_io = 16'd0;
                    end else begin
                        r.io_left = r.io_left - 16'd1;
                    end
                end
                // Keep the best candidates sorted by level, then index
                elig = in_use && r.state == TS_READY && r.arrival <= tick_reg;
                for (int j = 0; j < CORES; j++)
                    if (cand_v_reg[j] && cand_l_reg[j] <= r.level) pos = pos + 3'd1;
                if (elig) begin
                    for (int j = CORES - 1; j > 0; j--) begin
                        if (3'(j) > pos) begin
                            cand_v_next[j] = cand_v_reg[j-1];
                            cand_i_next[j] = cand_i_reg[j-1];
                            cand_l_next[j] = cand_l_reg[j-1];
                        end
                    end
                    for (int j = 0; j < CORES; j++) begin
                        if (3'(j) == pos) begin
                            cand_v_next[j] = 1'b1;
                            cand_i_next[j] = cnt_reg;
                            cand_l_next[j] = r.level;
                        end
                    end
                end
                cnt_next = cnt_reg + TIDX_W'(1);
                if (cnt_reg == TIDX_W'(TASK_SLOTS - 1)) phase_next = PH_ASSIGN;
            end

            PH_ASSIGN: begin
                // Idle cores take candidates in core order
                for (int c = 0; c < CORES; c++) begin
                    rb_next[c] = 1'b0;
                    rl_next[c] = 2'd0;
                    ro_next[c] = OC_IDLE;
                    if (NC_W'(c) < nc_reg && !cv_reg[c] && k < 3'(CORES)) begin
                        if (cand_v_reg[k[CIDX_W-1:0]]) begin
                            cv_next[c] = 1'b1;
                            ct_next[c] = cand_i_reg[k[CIDX_W-1:0]];
                            cq_next[c] = quantum_for(cand_l_reg[k[CIDX_W-1:0]]);
                            k = k + 3'd1;
                        end
                    end
                end
                done_next  = '0;
                cnt_next   = '0;
                phase_next = PH_RUN;
            end

            PH_RUN: begin
                for (int c = 0; c < CORES; c++) begin
                    if (NC_W'(c) < nc_reg && cv_reg[c] && ct_reg[c] == cnt_reg) begin
                        hit = 1'b1;
                        hc  = CIDX_W'(c);
                    end
                end
                // Run the core holding this slot for one tick
                if (hit) begin
                    rb_next[hc] = 1'b1;
                    rl_next[hc] = r.level;
                    run_new = (r.run_since_io != 16'hFFFF) ? r.run_since_io + 16'd1
                                                           : r.run_since_io;
                    q_new   = (cq_reg[hc] != '0) ? cq_reg[hc] - Q_W'(1) : cq_reg[hc];
                    r.run_since_io = run_new;
                    cq_next[hc]    = q_new;
                    r.state        = TS_RUN;
                    if (r.left <= 16'd1) begin
                        r.left      = 16'd0;
                        r.state     = TS_DONE;
                        cv_next[hc] = 1'b0;
                        ro_next[hc] = OC_FINISH;
                    end else begin
                        r.left = r.left - 16'd1;
                        if (r.io_every != 16'd0 && run_new >= r.io_every) begin
                            r.state     = TS_WAIT;
                            r.io_left   = r.io_time;
                            cv_next[hc] = 1'b0;
                            ro_next[hc] = OC_IOWAIT;
                        end else if (q_new == '0) begin
                            r.state     = TS_READY;
                            if (r.level < 2'd2) r.level = r.level + 2'd1;
                            cv_next[hc] = 1'b0;
                            ro_next[hc] = OC_EXPIRED;
                        end else begin
                            ro_next[hc] = OC_CONT;
                        end
                    end
                end
                if (in_use && r.state == TS_DONE) done_next = done_reg + NT_W'(1);
                cnt_next = cnt_reg + TIDX_W'(1);
                if (cnt_reg == TIDX_W'(TASK_SLOTS - 1)) begin
                    emit_next  = '0;
                    phase_next = PH_EMIT;
                end
            end

            PH_EMIT: begin
                // One result per cycle into the output register, while it is free or being taken
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.core_index  = emit_reg;
                    m_data_next.core_busy   = rb_reg[emit_reg];
                    m_data_next.task_index  = rb_reg[emit_reg] ? 4'(ct_reg[emit_reg]) : 4'd0;
                    m_data_next.run_level   = rl_reg[emit_reg];
                    m_data_next.outcome     = ro_reg[emit_reg];
                    m_data_next.tick_number = tick_reg;
                    m_data_next.all_done    = (done_reg == nt_reg);
                    m_data_next.last        = (NC_W'(emit_reg) + NC_W'(1) == nc_reg);
                    emit_next = emit_reg + CIDX_W'(1);
                    if (NC_W'(emit_reg) + NC_W'(1) == nc_reg) begin
                        tick_next  = tick_reg + 16'd1;
                        phase_next = PH_IDLE;
                    end
                end
            end

            default: phase_next = PH_IDLE;
        endcase

        head_next = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            act_cores_reg  <= NC_W'(1);
            task_count_reg <= NT_W'(16);
            tick_reg       <= '0;
            done_reg       <= '0;
            m_valid_reg    <= 1'b0;
            for (int c = 0; c < CORES; c++) cv_reg[c] <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            act_cores_reg  <= act_cores_next;
            task_count_reg <= task_count_next;
            tick_reg       <= tick_next;
            done_reg       <= done_next;
            m_valid_reg    <= m_valid_next;
            for (int c = 0; c < CORES; c++) cv_reg[c] <= cv_next[c];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        nc_reg     <= nc_next;
        nt_reg     <= nt_next;
        emit_reg   <= emit_next;
        m_data_reg <= m_data_next;
        for (int c = 0; c < CORES; c++) begin
            ct_reg[c]     <= ct_next[c];
            cq_reg[c]     <= cq_next[c];
            cand_v_reg[c] <= cand_v_next[c];
            cand_i_reg[c] <= cand_i_next[c];
            cand_l_reg[c] <= cand_l_next[c];
            rb_reg[c]     <= rb_next[c];
            rl_reg[c]     <= rl_next[c];
            ro_reg[c]     <= ro_next[c];
        end
    end

    assign s_ready = (phase_reg == PH_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
